/* hdl/rcfs_pkg.sv */
`timescale 1ns / 1ps

package rcfs_pkg;

  localparam int CHANNEL_COUNT   = 18;
  localparam int CH_W            = 5;
  localparam int CH_IDX_W        = $clog2(CHANNEL_COUNT);
  localparam int PULSE_W         = 12;
  localparam int HOLD_W          = 16;
  localparam int TIME_W          = 32;
  localparam int MAP_W           = 36;
  localparam int MAP_CHANNELS    = MAP_W / 2;
  localparam int SRC_W           = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 36;
  localparam int FLIGHT_CHANNELS = 4;
  localparam int THROTTLE_CH     = 3;

  localparam logic [PULSE_W-1:0] SET_MODE_VALUE   = 12'd1000;
  localparam logic [PULSE_W-1:0] LAST_OUT_RESET   = 12'd1500;
  localparam logic [PULSE_W-1:0] THROTTLE_RESET   = 12'd885;
  localparam logic [TIME_W-1:0]  DEADLINE_RESET   = 32'd300;

  localparam logic [PULSE_W-1:0] PULSE_MIN_RESET  = 12'd885;
  localparam logic [PULSE_W-1:0] PULSE_MAX_RESET  = 12'd2115;
  localparam logic [PULSE_W-1:0] MID_RESET        = 12'd1500;
  localparam logic [HOLD_W-1:0]  HOLD_TIME_RESET  = 16'd300;
  localparam logic [PULSE_W-1:0] CLAMP_MIN_RESET  = 12'd750;
  localparam logic [PULSE_W-1:0] CLAMP_MAX_RESET  = 12'd2250;
  localparam logic [MAP_W-1:0]   MODE_MAP_RESET   = 36'h555555500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_VALID_MIN  = 3'd0,
    REG_PULSE_VALID_MAX  = 3'd1,
    REG_MID_VALUE        = 3'd2,
    REG_HOLD_TIME_MS     = 3'd3,
    REG_CLAMP_MIN        = 3'd4,
    REG_CLAMP_MAX        = 3'd5,
    REG_THROTTLE_TO_MID  = 3'd6,
    REG_FAILSAFE_MODE    = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_AUTO     = 2'd0,
    MODE_HOLD     = 2'd1,
    MODE_SET      = 2'd2,
    MODE_HOLD_ALT = 2'd3
  } fs_mode_t;

  typedef enum logic [SRC_W-1:0] {
    SRC_PULSE    = 2'd0,
    SRC_HELD     = 2'd1,
    SRC_FAILSAFE = 2'd2
  } value_src_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_valid_min;
    logic [PULSE_W-1:0] pulse_valid_max;
    logic [PULSE_W-1:0] mid_value;
    logic [HOLD_W-1:0]  hold_time_ms;
    logic [PULSE_W-1:0] clamp_min;
    logic [PULSE_W-1:0] clamp_max;
    logic               throttle_fails_to_mid;
    logic [MAP_W-1:0]   failsafe_mode_map;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]    channel_index;
    logic [PULSE_W-1:0] pulse_sample;
    logic               link_ok;
    logic               failsafe_switch;
    logic [TIME_W-1:0]  now_ms;
    logic               frame_start;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0]    channel_out;
    logic [PULSE_W-1:0] channel_value;
    logic [SRC_W-1:0]   value_source;
    logic               flight_valid;
  } result_t;

endpackage

/* hdl/rcfs_in_if.sv */
`timescale 1ns / 1ps

interface rcfs_in_if;
  import rcfs_pkg::*;

  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    channel_index;
  logic [PULSE_W-1:0] pulse_sample;
  logic               link_ok;
  logic               failsafe_switch;
  logic [TIME_W-1:0]  now_ms;
  logic               frame_start;

  modport source (
    output valid, channel_index, pulse_sample, link_ok, failsafe_switch, now_ms,
           frame_start,
    input  ready
  );

  modport sink (
    input  valid, channel_index, pulse_sample, link_ok, failsafe_switch, now_ms,
           frame_start,
    output ready
  );
endinterface

/* hdl/rcfs_out_if.sv */
`timescale 1ns / 1ps

interface rcfs_out_if;
  import rcfs_pkg::*;

  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    channel_out;
  logic [PULSE_W-1:0] channel_value;
  logic [SRC_W-1:0]   value_source;
  logic               flight_valid;

  modport source (
    output valid, channel_out, channel_value, value_source, flight_valid,
    input  ready
  );

  modport sink (
    input  valid, channel_out, channel_value, value_source, flight_valid,
    output ready
  );
endinterface

/* hdl/rcfs_cfg_regs.sv */
`timescale 1ns / 1ps

module rcfs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rcfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcfs_pkg::CFG_DATA_W-1:0] cfg_data,
  output rcfs_pkg::cfg_t                  cfg
);
  import rcfs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_valid_min       <= PULSE_MIN_RESET;
      cfg.pulse_valid_max       <= PULSE_MAX_RESET;
      cfg.mid_value             <= MID_RESET;
      cfg.hold_time_ms          <= HOLD_TIME_RESET;
      cfg.clamp_min             <= CLAMP_MIN_RESET;
      cfg.clamp_max             <= CLAMP_MAX_RESET;
      cfg.throttle_fails_to_mid <= 1'b0;
      cfg.failsafe_mode_map     <= MODE_MAP_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_PULSE_VALID_MIN: cfg.pulse_valid_min       <= cfg_data[PULSE_W-1:0];
        REG_PULSE_VALID_MAX: cfg.pulse_valid_max       <= cfg_data[PULSE_W-1:0];
        REG_MID_VALUE:       cfg.mid_value             <= cfg_data[PULSE_W-1:0];
        REG_HOLD_TIME_MS:    cfg.hold_time_ms          <= cfg_data[HOLD_W-1:0];
        REG_CLAMP_MIN:       cfg.clamp_min             <= cfg_data[PULSE_W-1:0];
        REG_CLAMP_MAX:       cfg.clamp_max             <= cfg_data[PULSE_W-1:0];
        REG_THROTTLE_TO_MID: cfg.throttle_fails_to_mid <= cfg_data[0];
        REG_FAILSAFE_MODE:   cfg.failsafe_mode_map     <= cfg_data[MAP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hdl/rcfs_in_reg.sv */
`timescale 1ns / 1ps

module rcfs_in_reg (
  input  logic            clk,
  input  logic            rst,
  rcfs_in_if.sink         in_ch,
  input  logic            take,
  output logic            item_valid,
  output rcfs_pkg::item_t item
);
  import rcfs_pkg::*;

  // free when empty or when the held beat moves on this cycle
  assign in_ch.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.channel_index   <= in_ch.channel_index;
      item.pulse_sample    <= in_ch.pulse_sample;
      item.link_ok         <= in_ch.link_ok;
      item.failsafe_switch <= in_ch.failsafe_switch;
      item.now_ms          <= in_ch.now_ms;
      item.frame_start     <= in_ch.frame_start;
    end
  end

endmodule

/* hdl/rcfs_proc.sv */
`timescale 1ns / 1ps

module rcfs_proc (
  input  logic            clk,
  input  logic            rst,
  input  rcfs_pkg::cfg_t  cfg,
  input  logic            item_valid,
  input  rcfs_pkg::item_t item,
  output logic            take,
  output logic            res_valid,
  input  logic            res_ready,
  output rcfs_pkg::result_t res
);
  import rcfs_pkg::*;

  logic [PULSE_W-1:0] last_output   [CHANNEL_COUNT];
  logic [TIME_W-1:0]  hold_deadline [CHANNEL_COUNT];
  logic               flag;

  logic [1:0]          mode_arr [CHANNEL_COUNT];
  logic                in_range;
  logic [CH_IDX_W-1:0] sel;
  logic                flag_cur;
  logic                flag_next;
  logic                chan_valid;
  logic                holding;
  logic [TIME_W-1:0]   diff;
  logic [TIME_W-1:0]   deadline_next;
  logic [PULSE_W-1:0]  last_val;
  logic [PULSE_W-1:0]  fs_val;
  logic [PULSE_W-1:0]  raw_val;
  logic [PULSE_W-1:0]  clamped;
  logic [SRC_W-1:0]    src;
  fs_mode_t            mode;

  // channels beyond the map read as auto
  for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_mode
    if (c < MAP_CHANNELS) begin : g_map
      assign mode_arr[c] = cfg.failsafe_mode_map[2*c +: 2];
    end else begin : g_nomap
      assign mode_arr[c] = 2'd0;
    end
  end

  assign take = item_valid && (!res_valid || res_ready);

  always_comb begin
    in_range      = {1'b0, item.channel_index} < (CH_W+1)'(CHANNEL_COUNT);
    sel           = in_range ? item.channel_index[CH_IDX_W-1:0] : '0;
    mode          = in_range ? fs_mode_t'(mode_arr[sel]) : MODE_AUTO;
    last_val      = last_output[sel];
    flag_cur      = item.frame_start ? (item.link_ok && !item.failsafe_switch) : flag;
    chan_valid    = flag_cur && (item.pulse_sample >= cfg.pulse_valid_min) &&
                    (item.pulse_sample <= cfg.pulse_valid_max);
    diff          = item.now_ms - hold_deadline[sel];
    holding       = diff[TIME_W-1];
    deadline_next = item.now_ms + {{(TIME_W-HOLD_W){1'b0}}, cfg.hold_time_ms};

    case (mode)
      MODE_AUTO: begin
        if (item.channel_index < CH_W'(FLIGHT_CHANNELS)) begin
          if (item.channel_index == CH_W'(THROTTLE_CH)) begin
            fs_val = cfg.throttle_fails_to_mid ? cfg.mid_value : cfg.pulse_valid_min;
          end else begin
            fs_val = cfg.mid_value;
          end
        end else begin
          fs_val = item.failsafe_switch ? item.pulse_sample : last_val;
        end
      end
      MODE_SET: fs_val = SET_MODE_VALUE;
      default:  fs_val = item.failsafe_switch ? item.pulse_sample : last_val;
    endcase

    raw_val   = '0;
    src       = SRC_PULSE;
    flag_next = flag_cur;
    if (in_range) begin
      if (item.failsafe_switch) begin
        raw_val = fs_val;
        src     = SRC_FAILSAFE;
      end else if (!chan_valid) begin
        if (holding) begin
          raw_val = last_val;
          src     = SRC_HELD;
        end else begin
          // a flight channel in failsafe drops the frame for later channels
          if (item.channel_index < CH_W'(FLIGHT_CHANNELS)) begin
            flag_next = 1'b0;
          end
          raw_val = fs_val;
          src     = SRC_FAILSAFE;
        end
      end else begin
        raw_val = item.pulse_sample;
        src     = SRC_PULSE;
      end
    end

    if (!in_range) begin
      clamped = '0;
    end else if (raw_val < cfg.clamp_min) begin
      clamped = cfg.clamp_min;
    end else if (raw_val > cfg.clamp_max) begin
      clamped = cfg.clamp_max;
    end else begin
      clamped = raw_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        last_output[i]   <= (i == THROTTLE_CH) ? THROTTLE_RESET : LAST_OUT_RESET;
        hold_deadline[i] <= DEADLINE_RESET;
      end
    end else if (take) begin
      flag <= flag_next;
      if (in_range) begin
        last_output[sel] <= clamped;
        if (chan_valid) begin
          hold_deadline[sel] <= deadline_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.channel_out   <= item.channel_index;
      res.channel_value <= clamped;
      res.value_source  <= src;
      res.flight_valid  <= flag_next;
    end
  end

endmodule

/* hdl/rc_channel_failsafe_hold_top.sv */
`timescale 1ns / 1ps

// An accepted input beat passes the input register, then decision, clamp and channel
// state update into the result register. Throughput: one beat per cycle unless the
// output stalls; the per-channel state is read and written in the same cycle, so
// back-to-back beats on one channel see each other's updates.
// Reset (rst, synchronous): config registers to defaults, last outputs to 1500
// (throttle 885), deadlines to 300, frame-valid flag cleared, both stages emptied.
module rc_channel_failsafe_hold_top (
  input  logic                            clk,
  input  logic                            rst,
  rcfs_in_if.sink                         in_ch,
  rcfs_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [rcfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rcfs_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    item_valid;
  logic    take;
  logic    res_valid;

  rcfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rcfs_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  rcfs_proc u_proc (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .res_valid  (res_valid),
    .res_ready  (out_ch.ready),
    .res        (res)
  );

  assign out_ch.valid         = res_valid;
  assign out_ch.channel_out   = res.channel_out;
  assign out_ch.channel_value = res.channel_value;
  assign out_ch.value_source  = res.value_source;
  assign out_ch.flight_valid  = res.flight_valid;

endmodule

/* verif/rc_channel_failsafe_hold_top_tb.sv */
`timescale 1ns / 1ps

module rc_channel_failsafe_hold_top_tb;
  import rcfs_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned LONG_STALL  = 60;
  localparam int unsigned PHASE_ITEMS = 156;
  localparam int unsigned MAX_REPORTS = 60;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rcfs_in_if  in_ch ();
  rcfs_out_if out_ch ();

  rc_channel_failsafe_hold_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block's settings and per-channel state
  cfg_t               model_cfg;
  logic [PULSE_W-1:0] last_out [CHANNEL_COUNT];
  logic [TIME_W-1:0]  deadline [CHANNEL_COUNT];
  logic               frame_ok;

  item_t   beats_to_send [$];
  result_t results_due [$];

  int unsigned       send_gap = 0;
  int unsigned       recv_gap = 0;
  int unsigned       stall_left = 0;
  int unsigned       beats_seen = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       mismatches = 0;
  bit                send_calm = 1'b0;
  bit                recv_calm = 1'b0;
  logic [TIME_W-1:0] clock_ms;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic logic [PULSE_W-1:0] failsafe_pick(input int unsigned ch,
      input logic [PULSE_W-1:0] pulse, input logic sw);
    fs_mode_t mode;
    mode = fs_mode_t'(model_cfg.failsafe_mode_map[2*ch +: 2]);
    if (mode == MODE_AUTO && ch < FLIGHT_CHANNELS) begin
      if (ch == THROTTLE_CH)
        return model_cfg.throttle_fails_to_mid ? model_cfg.mid_value
                                               : model_cfg.pulse_valid_min;
      return model_cfg.mid_value;
    end
    if (mode == MODE_SET)
      return SET_MODE_VALUE;
    return sw ? pulse : last_out[ch];
  endfunction

  function automatic result_t channel_result(input item_t it);
    result_t            r;
    int unsigned        ch;
    logic               in_range;
    logic [PULSE_W-1:0] value;
    logic [TIME_W-1:0]  late;
    value_src_t         src;
    ch = 32'(it.channel_index);
    value = '0;
    src = SRC_PULSE;
    if (it.frame_start)
      frame_ok = it.link_ok && !it.failsafe_switch;
    if (ch < CHANNEL_COUNT) begin
      in_range = frame_ok && it.pulse_sample >= model_cfg.pulse_valid_min &&
                 it.pulse_sample <= model_cfg.pulse_valid_max;
      if (in_range)
        deadline[ch] = it.now_ms + TIME_W'(model_cfg.hold_time_ms);
      // hold while now is still before the deadline, wrapping compare
      late = it.now_ms - deadline[ch];
      if (it.failsafe_switch) begin
        value = failsafe_pick(ch, it.pulse_sample, 1'b1);
        src = SRC_FAILSAFE;
      end else if (!in_range && late[TIME_W-1]) begin
        value = last_out[ch];
        src = SRC_HELD;
      end else if (!in_range) begin
        if (ch < FLIGHT_CHANNELS)
          frame_ok = 1'b0;
        value = failsafe_pick(ch, it.pulse_sample, 1'b0);
        src = SRC_FAILSAFE;
      end else begin
        value = it.pulse_sample;
      end
      if (value < model_cfg.clamp_min)
        value = model_cfg.clamp_min;
      else if (value > model_cfg.clamp_max)
        value = model_cfg.clamp_max;
      last_out[ch] = value;
    end
    r.channel_out   = it.channel_index;
    r.channel_value = value;
    r.value_source  = src;
    r.flight_valid  = frame_ok;
    return r;
  endfunction

  task automatic queue_item(input logic [CH_W-1:0] ch, input logic [PULSE_W-1:0] pulse,
      input logic link, input logic sw, input logic [TIME_W-1:0] now, input logic start);
    item_t it;
    it.channel_index   = ch;
    it.pulse_sample    = pulse;
    it.link_ok         = link;
    it.failsafe_switch = sw;
    it.now_ms          = now;
    it.frame_start     = start;
    beats_to_send.push_back(it);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PULSE_VALID_MIN: model_cfg.pulse_valid_min       = val[PULSE_W-1:0];
      REG_PULSE_VALID_MAX: model_cfg.pulse_valid_max       = val[PULSE_W-1:0];
      REG_MID_VALUE:       model_cfg.mid_value             = val[PULSE_W-1:0];
      REG_HOLD_TIME_MS:    model_cfg.hold_time_ms          = val[HOLD_W-1:0];
      REG_CLAMP_MIN:       model_cfg.clamp_min             = val[PULSE_W-1:0];
      REG_CLAMP_MAX:       model_cfg.clamp_max             = val[PULSE_W-1:0];
      REG_THROTTLE_TO_MID: model_cfg.throttle_fails_to_mid = val[0];
      REG_FAILSAFE_MODE:   model_cfg.failsafe_mode_map     = val[MAP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(REG_PULSE_VALID_MIN, CFG_DATA_W'(c.pulse_valid_min));
    write_reg(REG_PULSE_VALID_MAX, CFG_DATA_W'(c.pulse_valid_max));
    write_reg(REG_MID_VALUE, CFG_DATA_W'(c.mid_value));
    write_reg(REG_HOLD_TIME_MS, CFG_DATA_W'(c.hold_time_ms));
    write_reg(REG_CLAMP_MIN, CFG_DATA_W'(c.clamp_min));
    write_reg(REG_CLAMP_MAX, CFG_DATA_W'(c.clamp_max));
    write_reg(REG_THROTTLE_TO_MID, CFG_DATA_W'(c.throttle_fails_to_mid));
    write_reg(REG_FAILSAFE_MODE, CFG_DATA_W'(c.failsafe_mode_map));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly whole or cut-short frames in channel order, with loose noise beats between
  task automatic gen_traffic(input int unsigned count);
    int unsigned made;
    int unsigned span;
    int unsigned k;
    logic        link;
    logic        sw;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) < 8) begin
        span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, CHANNEL_COUNT) : CHANNEL_COUNT;
        link = ($urandom_range(0, 6) != 0);
        sw   = ($urandom_range(0, 14) == 0);
        clock_ms += ($urandom_range(0, 7) == 0) ? $urandom_range(0, 70000)
                                                : $urandom_range(0, 40);
        for (k = 0; k < span; k++) begin
          queue_item(CH_W'(k),
                     PULSE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                          : $urandom_range(850, 2150)),
                     link, sw, clock_ms, k == 0);
        end
        made += span;
      end else begin
        queue_item(CH_W'($urandom_range(0, 31)), PULSE_W'($urandom_range(0, 4095)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 1) ? $urandom() : clock_ms,
                   1'($urandom_range(0, 1)));
        made++;
      end
    end
  endtask

  task automatic wait_idle();
    do
      @(negedge clk);
    while (beats_to_send.size() != 0 || in_ch.valid || results_due.size() != 0);
  endtask

  task automatic run_phase(input cfg_t c, input logic [TIME_W-1:0] start_ms);
    apply_settings(c);
    @(negedge clk);
    clock_ms = start_ms;
    gen_traffic(PHASE_ITEMS);
    wait_idle();
  endtask

  // Sender: hold each beat until taken, then wait the drawn gap
  always @(posedge clk) begin : drive_beats
    item_t seen;
    item_t nxt;
    logic  fire;
    fire = in_ch.valid && in_ch.ready;
    if (rst) begin
      in_ch.valid           <= 1'b0;
      in_ch.channel_index   <= '0;
      in_ch.pulse_sample    <= '0;
      in_ch.link_ok         <= 1'b0;
      in_ch.failsafe_switch <= 1'b0;
      in_ch.now_ms          <= '0;
      in_ch.frame_start     <= 1'b0;
      send_gap              <= 0;
    end else begin
      if (fire) begin
        seen.channel_index   = in_ch.channel_index;
        seen.pulse_sample    = in_ch.pulse_sample;
        seen.link_ok         = in_ch.link_ok;
        seen.failsafe_switch = in_ch.failsafe_switch;
        seen.now_ms          = in_ch.now_ms;
        seen.frame_start     = in_ch.frame_start;
        results_due.push_back(channel_result(seen));
      end
      if (!in_ch.valid || fire) begin
        if (send_gap != 0) begin
          send_gap    <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (beats_to_send.size() != 0) begin
          nxt = beats_to_send.pop_front();
          in_ch.channel_index   <= nxt.channel_index;
          in_ch.pulse_sample    <= nxt.pulse_sample;
          in_ch.link_ok         <= nxt.link_ok;
          in_ch.failsafe_switch <= nxt.failsafe_switch;
          in_ch.now_ms          <= nxt.now_ms;
          in_ch.frame_start     <= nxt.frame_start;
          in_ch.valid           <= 1'b1;
          send_gap              <= draw_wait(send_calm);
          if ($urandom_range(0, 39) == 0)
            send_calm <= !send_calm;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each beat with the oldest expectation, then stall as drawn
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $error("channel_out: no result expected, got channel %0d", out_ch.channel_out);
        end else begin
          want = results_due.pop_front();
          check_field("channel_out", 32'(want.channel_out), 32'(out_ch.channel_out));
          check_field("channel_value", 32'(want.channel_value),
                      32'(out_ch.channel_value));
          check_field("value_source", 32'(want.value_source), 32'(out_ch.value_source));
          check_field("flight_valid", 32'(want.flight_valid), 32'(out_ch.flight_valid));
        end
        beats_seen++;
        // long hold-off so the pipeline backs up into the input
        if (beats_seen == 100 || beats_seen == 400)
          stall_left = LONG_STALL;
        recv_gap = draw_wait(recv_calm);
        if ($urandom_range(0, 39) == 0)
          recv_calm = !recv_calm;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    cfg_t c;
    int   i;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;

    model_cfg.pulse_valid_min       = PULSE_MIN_RESET;
    model_cfg.pulse_valid_max       = PULSE_MAX_RESET;
    model_cfg.mid_value             = MID_RESET;
    model_cfg.hold_time_ms          = HOLD_TIME_RESET;
    model_cfg.clamp_min             = CLAMP_MIN_RESET;
    model_cfg.clamp_max             = CLAMP_MAX_RESET;
    model_cfg.throttle_fails_to_mid = 1'b0;
    model_cfg.failsafe_mode_map     = MODE_MAP_RESET;
    for (i = 0; i < CHANNEL_COUNT; i++) begin
      last_out[i] = LAST_OUT_RESET;
      deadline[i] = DEADLINE_RESET;
    end
    last_out[THROTTLE_CH] = THROTTLE_RESET;
    frame_ok = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed beats on the reset settings
    queue_item(0, 1500, 1, 0, 10, 1);                 // clean pulse passes
    queue_item(1, 884, 1, 0, 10, 0);                  // just under range: hold
    queue_item(2, 2116, 1, 0, 10, 0);                 // just over range: hold
    queue_item(3, 0, 1, 0, 400, 0);                   // expired throttle drops the flag
    queue_item(4, 1500, 1, 0, 400, 0);                // aux with flag down, hold mode keeps last output
    queue_item(0, 1500, 0, 0, 400, 1);                // link lost at frame start
    queue_item(0, 4095, 1, 1, 500, 1);                // switch forces failsafe
    queue_item(5, 4095, 1, 1, 500, 0);                // hold under switch takes raw pulse
    queue_item(5, 0, 1, 1, 500, 0);                   // low side of the clamp
    queue_item(0, 885, 1, 0, 600, 1);                 // range edges accepted
    queue_item(1, 2115, 1, 0, 600, 0);
    queue_item(2, 4095, 1, 0, 600, 0);
    queue_item(17, 1000, 1, 0, 600, 0);               // last channel
    queue_item(18, 4095, 1, 0, 600, 0);               // first index past the channels
    queue_item(31, 0, 1, 0, 600, 1);                  // out of range still reloads flag
    queue_item(3, 2000, 1, 0, 32'hFFFF_FFF0, 0);      // deadline wraps past zero
    queue_item(3, 0, 1, 0, 32'h0000_0010, 0);         // still holding across the wrap
    queue_item(3, 0, 1, 0, 32'h0000_0200, 0);         // past the wrapped deadline
    queue_item(16, 4095, 0, 1, 32'hFFFF_FFFF, 1);
    wait_idle();

    c.pulse_valid_min       = PULSE_W'($urandom_range(800, 1000));
    c.pulse_valid_max       = PULSE_W'($urandom_range(2000, 2200));
    c.mid_value             = PULSE_W'($urandom_range(1400, 1600));
    c.hold_time_ms          = HOLD_W'($urandom_range(50, 500));
    c.clamp_min             = PULSE_W'($urandom_range(700, 900));
    c.clamp_max             = PULSE_W'($urandom_range(2100, 2300));
    c.throttle_fails_to_mid = 1'($urandom_range(0, 1));
    c.failsafe_mode_map     = {4'($urandom_range(0, 15)), $urandom()};
    run_phase(c, 1000);

    // widest window, no hold time, every mode reads as hold
    c.pulse_valid_min       = 0;
    c.pulse_valid_max       = 4095;
    c.mid_value             = 0;
    c.hold_time_ms          = 0;
    c.clamp_min             = 0;
    c.clamp_max             = 4095;
    c.throttle_fails_to_mid = 0;
    c.failsafe_mode_map     = 36'hF_FFFF_FFFF;
    run_phase(c, 0);

    // empty window, longest hold, crossed clamps, all auto
    c.pulse_valid_min       = 4095;
    c.pulse_valid_max       = 0;
    c.mid_value             = 4095;
    c.hold_time_ms          = 16'hFFFF;
    c.clamp_min             = 3000;
    c.clamp_max             = 1000;
    c.throttle_fails_to_mid = 1;
    c.failsafe_mode_map     = '0;
    run_phase(c, 32'hFFFF_F000);

    // every channel fails to the fixed set value
    c.pulse_valid_min       = 1000;
    c.pulse_valid_max       = 2000;
    c.mid_value             = 1500;
    c.hold_time_ms          = 16'hFFFF;
    c.clamp_min             = 0;
    c.clamp_max             = 4095;
    c.throttle_fails_to_mid = 1;
    c.failsafe_mode_map     = 36'hA_AAAA_AAAA;
    run_phase(c, $urandom());

    c.pulse_valid_min       = PULSE_MIN_RESET;
    c.pulse_valid_max       = PULSE_MAX_RESET;
    c.mid_value             = MID_RESET;
    c.hold_time_ms          = HOLD_TIME_RESET;
    c.clamp_min             = CLAMP_MIN_RESET;
    c.clamp_max             = CLAMP_MAX_RESET;
    c.throttle_fails_to_mid = 0;
    c.failsafe_mode_map     = {4'($urandom_range(0, 15)), $urandom()};
    run_phase(c, $urandom());

    // let any stray beat surface before the verdict
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
